// ===== src/sfa_pkg.sv =====
// Shared constants, types and size-class functions of the segregated-fit allocator.
// Depends on nothing; sfa_bins and the allocator import it.
package sfa_pkg;

  localparam int unsigned AddrW      = 16;
  localparam int unsigned LinkW      = 17;
  localparam int unsigned BinIdxW    = 5;
  localparam int unsigned HeapBytesDef = 65536;
  localparam int unsigned BinCountDef  = 17;
  localparam int unsigned SmallTop   = 6;
  localparam int unsigned MinBlock   = 16;
  localparam logic [16:0] LimitReset = 17'h10000;

  typedef struct packed {
    logic               en;
    logic [BinIdxW-1:0] idx;
    logic [LinkW-1:0]   data;
  } bin_wr_t;

  // Block size of a request: payload plus header, rounded up to 8, at least 16.
  function automatic logic [16:0] block_of(input logic [15:0] size);
    logic [16:0] b;
    b = (17'(size) + 17'd15) & ~17'd7;
    return (b < 17'(MinBlock)) ? 17'(MinBlock) : b;
  endfunction

  // Bin of a block size; sizes of 64 and above take the ceiling of the base-two logarithm.
  function automatic logic [BinIdxW-1:0] class_of(input logic [16:0] bsize);
    logic [16:0]        m;
    logic [BinIdxW-1:0] k;
    m = bsize - 17'd1;
    k = '0;
    for (int b = 0; b < 17; b++) begin
      if (m[b]) k = BinIdxW'(b + 1);
    end
    if (bsize < 17'd64) k = BinIdxW'(bsize[5:3]) - BinIdxW'(2);
    return k;
  endfunction

endpackage

// ===== src/sfa_in_if.sv =====
// Request channel of the allocator: valid/ready handshake with mode, size and address.
// Depends on nothing.
interface sfa_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] request_size;
  logic [15:0] block_address;

  modport source (output valid, mode, request_size, block_address, input ready);
  modport sink   (input valid, mode, request_size, block_address, output ready);
endinterface

// ===== src/sfa_out_if.sv =====
// Result channel of the allocator: valid/ready handshake with address and failure flag.
// Depends on nothing.
interface sfa_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_address;
  logic        failed;

  modport source (output valid, result_address, failed, input ready);
  modport sink   (input valid, result_address, failed, output ready);
endinterface

// ===== src/sfa_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module sfa_ram #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/sfa_bins.sv =====
// Bin head register file: one link word per bin, cleared to empty at reset.
// Depends on sfa_pkg for the link width and the write struct.
module sfa_bins #(
  parameter int unsigned BinCount = 17
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [sfa_pkg::BinIdxW-1:0]  rd_idx_i,
  output logic [sfa_pkg::LinkW-1:0]    rd_data_o,
  input  sfa_pkg::bin_wr_t             wr_i
);
  import sfa_pkg::*;

  localparam int unsigned BW = $clog2(BinCount);

  logic [LinkW-1:0] head_q [BinCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BinCount; b++) head_q[b] <= '0;
    end else if (wr_i.en && (wr_i.idx < BinIdxW'(BinCount))) begin
      head_q[wr_i.idx[BW-1:0]] <= wr_i.data;
    end
  end

  assign rd_data_o = (rd_idx_i < BinIdxW'(BinCount)) ? head_q[rd_idx_i[BW-1:0]] : '0;
endmodule

// ===== src/segregated_fit_allocator.sv =====
// Segregated-fit allocator, one word in flight. A free reads its block header and pushes the
// block on its bin, with no push for a null address or a bad header; an allocate does a bin
// scan, then a halving loop or a break grow, all on the one heap RAM port.
// The next word is accepted in the cycle after its result is loaded into the output register,
// where it waits for the sink; a stalled sink only holds back the following result.
// Reset empties all bins, clears the break and sets the limit to 65536; no clearing pass.
module segregated_fit_allocator #(
  parameter int unsigned HEAP_BYTES = sfa_pkg::HeapBytesDef,
  parameter int unsigned BIN_COUNT  = sfa_pkg::BinCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  sfa_in_if.sink      in_i,
  sfa_out_if.source   out_o
);
  import sfa_pkg::*;

  localparam int unsigned Words = HEAP_BYTES / 8;
  localparam int unsigned AW    = $clog2(Words);
  localparam int unsigned IW    = ((AW > 13) ? AW : 13) + 1;
  localparam logic [16:0] LimTop = (HEAP_BYTES < 65536) ? 17'(HEAP_BYTES) : 17'h10000;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_FWAIT = 11'b000_0000_0010,
    S_CLASS = 11'b000_0000_0100,
    S_SCAN  = 11'b000_0000_1000,
    S_POP   = 11'b000_0001_0000,
    S_SPLIT = 11'b000_0010_0000,
    S_REM   = 11'b000_0100_0000,
    S_GROW  = 11'b000_1000_0000,
    S_FPUSH = 11'b001_0000_0000,
    S_FIN   = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic               mode_q, mode_d;
  logic [15:0]        size_q, size_d;
  logic [15:0]        x_q, x_d;
  logic [16:0]        bsize_q, bsize_d;
  logic [BinIdxW-1:0] idx_q, idx_d, i_q, i_d, j_q, j_d;
  logic [16:0]        brk_q, brk_d;
  logic [16:0]        limit_q;
  logic [15:0]        res_q, res_d;
  logic               fail_q, fail_d;
  logic               rd_ok_q;
  logic               out_valid_q, out_fail_q;
  logic [15:0]        out_addr_q;

  logic               mem_we;
  logic [15:0]        mem_addr;
  logic [LinkW-1:0]   mem_wdata, mem_rdata, rd_word;
  logic [IW-1:0]      widx;
  logic               in_range;
  logic [BinIdxW-1:0] bin_rd_idx;
  logic [LinkW-1:0]   bin_head;
  bin_wr_t            bin_wr;
  logic               out_load;

  logic [BinIdxW-1:0] jm1, lo, rem_bin;
  logic [6:0]         have, rem;
  logic [17:0]        grow;
  logic [16:0]        lim;

  assign widx     = IW'(mem_addr[15:3]);
  assign in_range = widx < IW'(Words);
  assign rd_word  = rd_ok_q ? mem_rdata : '0;

  sfa_ram #(.Width(LinkW), .Depth(Words)) u_heap (
    .clk_i   (clk_i),
    .we_i    (mem_we && in_range),
    .waddr_i (widx[AW-1:0]),
    .wdata_i (mem_wdata),
    .raddr_i (widx[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  sfa_bins #(.BinCount(BIN_COUNT)) u_bins (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (bin_rd_idx),
    .rd_data_o (bin_head),
    .wr_i      (bin_wr)
  );

  assign jm1     = j_q - BinIdxW'(1);
  assign lo      = ((idx_q + BinIdxW'(1)) > BinIdxW'(SmallTop + 1)) ?
                   (idx_q + BinIdxW'(1)) : BinIdxW'(SmallTop + 1);
  assign have    = (i_q > BinIdxW'(SmallTop)) ? 7'd64 : 7'((i_q + BinIdxW'(2)) << 3);
  assign rem     = have - bsize_q[6:0];
  assign rem_bin = BinIdxW'(rem[6:3]) - BinIdxW'(2);
  assign grow    = (bsize_q > 17'd64) ? (18'd1 << idx_q) : 18'(bsize_q);
  assign lim     = (limit_q < LimTop) ? limit_q : LimTop;

  assign in_i.ready = (state_q == S_IDLE);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    size_d     = size_q;
    x_d        = x_q;
    bsize_d    = bsize_q;
    idx_d      = idx_q;
    i_d        = i_q;
    j_d        = j_q;
    brk_d      = brk_q;
    res_d      = res_q;
    fail_d     = fail_q;
    mem_we     = 1'b0;
    mem_addr   = x_q;
    mem_wdata  = '0;
    bin_rd_idx = i_q;
    bin_wr     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          mode_d = in_i.mode;
          size_d = in_i.request_size;
          res_d  = '0;
          fail_d = 1'b0;
          if (!in_i.mode) begin
            state_d = S_CLASS;
          end else if (in_i.block_address < 16'd8) begin
            state_d = S_OUT;
          end else begin
            x_d      = (in_i.block_address - 16'd8) & ~16'd7;
            mem_addr = x_d;
            state_d  = S_FWAIT;
          end
        end
      end
      S_FWAIT: begin
        size_d  = rd_word[15:0];
        state_d = S_CLASS;
      end
      S_CLASS: begin
        bsize_d = block_of(size_q);
        idx_d   = class_of(bsize_d);
        i_d     = idx_d;
        if (idx_d >= BinIdxW'(BIN_COUNT)) begin
          state_d = mode_q ? S_OUT : S_GROW;
        end else begin
          state_d = mode_q ? S_FPUSH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (bin_head[16]) begin
          mem_addr = bin_head[15:0];
          x_d      = bin_head[15:0];
          state_d  = S_POP;
        end else if (i_q == BinIdxW'(BIN_COUNT - 1)) begin
          state_d = S_GROW;
        end else begin
          i_d = i_q + BinIdxW'(1);
        end
      end
      S_POP: begin
        bin_wr.en   = 1'b1;
        bin_wr.idx  = i_q;
        bin_wr.data = rd_word[16] ? rd_word : '0;
        j_d         = i_q;
        if (i_q == idx_q) state_d = S_FIN;
        else if (i_q > BinIdxW'(SmallTop)) state_d = S_SPLIT;
        else state_d = S_REM;
      end
      S_SPLIT: begin
        // Push the front half to the next bin down and carry on with the back half.
        bin_rd_idx  = jm1;
        mem_we      = 1'b1;
        mem_wdata   = bin_head;
        bin_wr.en   = 1'b1;
        bin_wr.idx  = jm1;
        bin_wr.data = {1'b1, x_q};
        x_d         = x_q + ((jm1 < BinIdxW'(16)) ? (16'd1 << jm1) : 16'd0);
        j_d         = jm1;
        if (jm1 == idx_q) state_d = S_FIN;
        else if (jm1 < lo) state_d = S_REM;
      end
      S_REM: begin
        bin_rd_idx = rem_bin;
        if (rem >= 7'(MinBlock)) begin
          mem_we      = 1'b1;
          mem_addr    = x_q + bsize_q[15:0];
          mem_wdata   = bin_head;
          bin_wr.en   = 1'b1;
          bin_wr.idx  = rem_bin;
          bin_wr.data = {1'b1, mem_addr};
        end
        state_d = S_FIN;
      end
      S_GROW: begin
        if ((brk_q > lim) || (grow > 18'(lim - brk_q))) begin
          fail_d  = 1'b1;
          state_d = S_OUT;
        end else begin
          x_d     = brk_q[15:0];
          brk_d   = brk_q + grow[16:0];
          state_d = S_FIN;
        end
      end
      S_FPUSH: begin
        bin_rd_idx  = idx_q;
        mem_we      = 1'b1;
        mem_wdata   = bin_head;
        bin_wr.en   = 1'b1;
        bin_wr.idx  = idx_q;
        bin_wr.data = {1'b1, x_q};
        state_d     = S_OUT;
      end
      S_FIN: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b0, size_q};
        res_d     = x_q + 16'd8;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      brk_q       <= '0;
      limit_q     <= LimitReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      brk_q       <= brk_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      out_valid_q <= (out_valid_q && !out_o.ready) || out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    size_q  <= size_d;
    x_q     <= x_d;
    bsize_q <= bsize_d;
    idx_q   <= idx_d;
    i_q     <= i_d;
    j_q     <= j_d;
    res_q   <= res_d;
    fail_q  <= fail_d;
    rd_ok_q <= in_range;
    if (out_load) begin
      out_addr_q <= res_q;
      out_fail_q <= fail_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_address = out_addr_q;
  assign out_o.failed         = out_fail_q;

`ifndef SYNTH
  a_break_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q <= 17'h10000) else $error("heap break beyond the address space");
  a_fail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_fail_q |-> out_addr_q == 16'd0)
    else $error("failed allocation returned an address");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == S_IDLE)
    else $error("result word not presented after completion");
`endif
endmodule

// ===== tb/sv/sfa_tb_pkg.sv =====
// Request mode codes shared by the allocator testbench and its checker.
// Depends on nothing.
package sfa_tb_pkg;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

endpackage

// ===== tb/sv/sfa_checker.sv =====
// Checker of the segregated-fit allocator: watches the request, result and limit ports,
// keeps its own copy of the bins, heap words and break, and compares every result word.
// Depends on sfa_tb_pkg and the channel interfaces sfa_in_if and sfa_out_if.
module sfa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  sfa_in_if           req_mon,
  sfa_out_if          res_mon,
  output int          error_count_o,
  output int          awaited_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfa_tb_pkg::*;

  localparam int unsigned Bins = 17;

  typedef struct packed {
    logic [15:0] address;
    logic        failed;
  } alloc_result_t;

  logic [16:0]   bin_head [Bins];
  logic [16:0]   heap_mem [8192];
  int unsigned   brk;
  int unsigned   limit;
  alloc_result_t awaited_results [$];
  int            errors;

  assign error_count_o = errors;

  function automatic int unsigned block_bytes(input logic [15:0] size);
    int unsigned b;
    b = (int'(size) + 15) & ~32'd7;
    return (b < 16) ? 16 : b;
  endfunction

  function automatic int unsigned bin_of(input int unsigned bsize);
    int unsigned k;
    k = 0;
    if (bsize < 64) return bsize / 8 - 2;
    while (k < 31 && (32'd1 << k) < bsize) k++;
    return k;
  endfunction

  function automatic void bin_insert(input int unsigned bin, input logic [15:0] addr);
    heap_mem[addr[15:3]] = bin_head[bin];
    bin_head[bin] = {1'b1, addr};
  endfunction

  function automatic logic [15:0] bin_take(input int unsigned bin);
    logic [15:0] a;
    logic [16:0] nx;
    a  = bin_head[bin][15:0];
    nx = heap_mem[a[15:3]];
    bin_head[bin] = nx[16] ? nx : 17'd0;
    return a;
  endfunction

  function automatic alloc_result_t predict_alloc(input logic [15:0] size);
    alloc_result_t r;
    int unsigned   bsize, idx, lo, have, rem, grow, lim;
    logic [15:0]   x;
    bsize = block_bytes(size);
    idx   = bin_of(bsize);
    r     = '0;
    if (idx < Bins) begin
      if (bin_head[idx][16]) begin
        x = bin_take(idx);
        heap_mem[x[15:3]] = {1'b0, size};
        r.address = x + 16'd8;
        return r;
      end
      for (int i = idx + 1; i < Bins; i++) begin
        if (!bin_head[i][16]) continue;
        x = bin_take(i);
        if (i > 6) begin
          lo = (idx + 1 > 7) ? idx + 1 : 7;
          // Halve the power-of-two block, keeping the back half each time.
          for (int j = i; j >= int'(lo); j--) begin
            bin_insert(j - 1, x);
            x = x + 16'(32'd1 << (j - 1));
            if (j - 1 == int'(idx)) begin
              heap_mem[x[15:3]] = {1'b0, size};
              r.address = x + 16'd8;
              return r;
            end
          end
          have = 64;
        end else begin
          have = (i + 2) * 8;
        end
        rem = have - bsize;
        if (rem >= 16) bin_insert(rem / 8 - 2, x + 16'(bsize));
        heap_mem[x[15:3]] = {1'b0, size};
        r.address = x + 16'd8;
        return r;
      end
    end
    grow = bsize;
    if (grow > 64) grow = 32'd1 << bin_of(grow);
    lim = (limit > 65536) ? 65536 : limit;
    if (brk > lim || grow > lim - brk) begin
      r.failed = 1'b1;
      return r;
    end
    x   = 16'(brk);
    brk = brk + grow;
    heap_mem[x[15:3]] = {1'b0, size};
    r.address = x + 16'd8;
    return r;
  endfunction

  function automatic void predict_free(input logic [15:0] addr);
    logic [15:0] blk;
    int unsigned idx;
    if (addr < 16'd8) return;
    blk = (addr - 16'd8) & ~16'd7;
    idx = bin_of(block_bytes(heap_mem[blk[15:3]][15:0]));
    if (idx >= Bins) return;
    bin_insert(idx, blk);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      foreach (bin_head[i]) bin_head[i] = '0;
      foreach (heap_mem[i]) heap_mem[i] = '0;
      brk    = 0;
      limit  = 65536;
      errors = 0;
      awaited_results.delete();
      awaited_count_o = 0;
    end else begin
      if (cfg_we_i) limit = cfg_wdata_i;
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.mode == ModeAlloc) begin
          awaited_results.push_back(predict_alloc(req_mon.request_size));
        end else begin
          predict_free(req_mon.block_address);
          awaited_results.push_back('0);
        end
      end
      if (res_mon.valid && res_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result word with no request waiting: address %0d failed %0d",
                 res_mon.result_address, res_mon.failed);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (res_mon.result_address !== want.address) begin
            $error("result_address: expected %0d, got %0d", want.address,
                   res_mon.result_address);
            errors++;
          end
          if (res_mon.failed !== want.failed) begin
            $error("failed: expected %0d, got %0d", want.failed, res_mon.failed);
            errors++;
          end
        end
      end
      awaited_count_o = awaited_results.size();
    end
  end

endmodule

// ===== tb/sv/tb_segregated_fit_allocator.sv =====
// Top of the allocator testbench: clock, reset, request stimulus, result back-pressure
// and the verdict. Depends on sfa_tb_pkg, the channel interfaces, sfa_checker and the block.
module tb_segregated_fit_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import sfa_tb_pkg::*;

  localparam int CycleLimit = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  int          error_count;
  int          awaited_count;
  int          cycles = 0;
  int          sent = 0;
  int          granted = 0;
  int          idle_mode = 0;
  logic [15:0] live_blocks [$];

  sfa_in_if  req_ch ();
  sfa_out_if res_ch ();

  segregated_fit_allocator DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (req_ch),
    .out_o      (res_ch)
  );

  sfa_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .req_mon        (req_ch),
    .res_mon        (res_ch),
    .error_count_o  (error_count),
    .awaited_count_o(awaited_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = ModeAlloc;
    req_ch.request_size = '0;
    req_ch.block_address = '0;
    res_ch.ready = 1'b0;
  end

  // Receiver stalls follow the current idling phase (2 and 3 stall the receiver).
  always @(posedge clk) begin
    if (idle_mode == 2 || idle_mode == 3)
      res_ch.ready <= ($urandom_range(99) >= (idle_mode == 3 ? 9 : 70));
    else
      res_ch.ready <= 1'b1;
  end

  // Addresses handed out are kept so that frees can name blocks that were handed out.
  always @(posedge clk) begin
    if (res_ch.valid && res_ch.ready && res_ch.result_address != 16'd0) begin
      granted++;
      live_blocks.push_back(res_ch.result_address);
      if (live_blocks.size() > 96) void'(live_blocks.pop_front());
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic mode, input logic [15:0] size,
                           input logic [15:0] addr);
    int idle_pct;
    idle_pct = (idle_mode == 1) ? 70 : (idle_mode == 3) ? 9 : 0;
    if ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= mode;
    req_ch.request_size <= size;
    req_ch.block_address <= addr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(input logic [16:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(120));
    if (r < 92) return 16'($urandom_range(2000));
    return 16'($urandom);
  endfunction

  // Null, a small address, or a handed-out block with random low bits added.
  function automatic logic [15:0] pick_free();
    int r;
    r = $urandom_range(99);
    if (r < 4 || live_blocks.size() == 0) return 16'd0;
    if (r < 8) return 16'($urandom_range(7));
    return live_blocks[$urandom_range(live_blocks.size() - 1)] + 16'($urandom_range(7));
  endfunction

  task automatic random_word();
    if ($urandom_range(99) < 58) send_word(ModeAlloc, pick_size(), 16'($urandom));
    else send_word(ModeFree, 16'($urandom), pick_free());
  endtask

  initial begin
    logic [16:0] limits [5];
    limits = '{17'd64, 17'($urandom_range(8192, 1024)), 17'd65536,
               17'($urandom_range(65536, 64)), 17'd65536};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: size extremes, the zero request, oversized requests, null and small frees.
    send_word(ModeAlloc, 16'd0, 16'd0);
    send_word(ModeAlloc, 16'd1, 16'hFFFF);
    send_word(ModeAlloc, 16'd56, 16'd0);
    send_word(ModeAlloc, 16'd57, 16'd0);
    send_word(ModeAlloc, 16'd120, 16'd0);
    send_word(ModeAlloc, 16'd1000, 16'd0);
    send_word(ModeAlloc, 16'hFFFF, 16'd0);
    send_word(ModeAlloc, 16'd65528, 16'd0);
    send_word(ModeFree, 16'hFFFF, 16'd0);
    send_word(ModeFree, 16'd0, 16'd7);
    drain();
    // Freed blocks are then reused exactly, split and halved by smaller requests.
    for (int i = 0; i < live_blocks.size(); i++)
      send_word(ModeFree, 16'd0, live_blocks[i] + 16'(i % 8));
    send_word(ModeAlloc, 16'd0, 16'd0);
    send_word(ModeAlloc, 16'd4, 16'd0);
    send_word(ModeAlloc, 16'd200, 16'd0);
    send_word(ModeAlloc, 16'd8, 16'd0);
    send_word(ModeAlloc, 16'd30, 16'd0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      idle_mode = ph % 4;
      write_limit(limits[ph]);
      for (int n = 0; n < 140; n++) begin
        random_word();
        // Once, hold the requests back until every result has come back.
        if (ph == 1 && n == 70) drain();
      end
      drain();
    end

    $display("Covered %0d request words over five limit settings and four idling phases;",
             sent);
    $display("%0d allocations returned a block.", granted);
    if (error_count == 0 && awaited_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
